### design/crrm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package crrm_pkg;

  // Fixed field widths.
  localparam int VAL_W = 32;
  localparam int ENT_W = 3 * VAL_W;
  localparam int CFG_W = 4;
  localparam int CMD_W = 2;
  localparam int STAGE_IDX_W = 3;
  localparam int SLOT_IDX_W = 6;

  // Default sizing of the remap table.
  localparam int MAX_STAGES_DEF = 8;
  localparam int SLOTS_PER_STAGE_DEF = 64;

  localparam logic [CFG_W-1:0] STAGE_COUNT_RST = CFG_W'(7);

  // Command codes; code 3 is unused and does nothing.
  localparam logic [CMD_W-1:0] CMD_WRITE   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_XLATE   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_MIN_RST = 2'd2;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN
  } ctl_state_t;

  typedef struct packed {
    logic clear_en;
    logic wr_entry;
    logic min_rst;
    logic load;
    logic scan_en;
    logic emit;
  } ctl_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic scan_done;
  } dp_status_t;

endpackage

`default_nettype wire

### design/crrm_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module crrm_ctrl (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          start,
  input  wire  [crrm_pkg::CMD_W-1:0]   in_cmd,
  input  crrm_pkg::dp_status_t         status,
  output crrm_pkg::ctl_cmd_t           cmd,
  output logic                         busy
);
  import crrm_pkg::*;

  ctl_state_t state_r;
  ctl_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = 1'b1;
    case (state_r)
      ST_CLEAR: begin
        cmd.clear_en = 1'b1;
        if (status.clear_done) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          case (in_cmd)
            CMD_WRITE:   cmd.wr_entry = 1'b1;
            CMD_XLATE: begin
              cmd.load  = 1'b1;
              state_nxt = ST_SCAN;
            end
            CMD_MIN_RST: cmd.min_rst = 1'b1;
            default:     ;
          endcase
        end
      end
      ST_SCAN: begin
        cmd.scan_en = 1'b1;
        if (status.scan_done) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

endmodule

`default_nettype wire

### design/crrm_dpath.sv
`timescale 1ns / 1ps
`default_nettype none

module crrm_dpath #(
  parameter int MAX_STAGES      = crrm_pkg::MAX_STAGES_DEF,
  parameter int SLOTS_PER_STAGE = crrm_pkg::SLOTS_PER_STAGE_DEF
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  crrm_pkg::ctl_cmd_t                cmd,
  output crrm_pkg::dp_status_t              status,
  input  wire                               cfg_wr_en,
  input  wire  [crrm_pkg::CFG_W-1:0]        cfg_wr_data,
  input  wire  [crrm_pkg::STAGE_IDX_W-1:0]  in_stage_index,
  input  wire  [crrm_pkg::SLOT_IDX_W-1:0]   in_slot_index,
  input  wire  [crrm_pkg::VAL_W-1:0]        in_dest_base,
  input  wire  [crrm_pkg::VAL_W-1:0]        in_source_base,
  input  wire  [crrm_pkg::VAL_W-1:0]        in_span_length,
  input  wire  [crrm_pkg::VAL_W-1:0]        in_seed_value,
  output logic                              out_valid,
  output logic [crrm_pkg::VAL_W-1:0]        out_mapped_value,
  output logic [crrm_pkg::VAL_W-1:0]        out_running_min
);
  import crrm_pkg::*;

  localparam int STG_W  = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;
  localparam int SLOT_W = (SLOTS_PER_STAGE > 1) ? $clog2(SLOTS_PER_STAGE) : 1;
  localparam int CNT_W  = $clog2(MAX_STAGES + 1);
  localparam int ADDR_W = STG_W + SLOT_W;
  localparam int DEPTH  = 1 << ADDR_W;

  logic [ENT_W-1:0] mem [DEPTH];

  logic [CFG_W-1:0]  stage_count_r;
  logic [ADDR_W-1:0] clr_cnt_r;
  logic [CNT_W-1:0]  n_r;
  logic [CNT_W-1:0]  iss_stage_r, iss_stage_nxt;
  logic [SLOT_W-1:0] iss_slot_r, iss_slot_nxt;
  logic              ev_vld_r, ev_vld_nxt;
  logic              ev_last_r;
  logic [ENT_W-1:0]  rd_data_r;
  logic [VAL_W-1:0]  v_r;
  logic [VAL_W-1:0]  min_r, min_nxt;
  logic              out_valid_r;
  logic [VAL_W-1:0]  out_mapped_r, out_min_r;

  logic              wr_in_range;
  logic              mem_we;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  logic [ENT_W-1:0]  wr_data;
  logic              issuing, iss_last;
  logic [VAL_W-1:0]  ent_dest, ent_src, ent_len, off;
  logic              hit;
  logic [CNT_W-1:0]  n_load;

  // Table write port: clearing sweep or an entry write.
  assign wr_in_range = (32'(in_stage_index) < 32'(MAX_STAGES)) &&
                       (32'(in_slot_index) < 32'(SLOTS_PER_STAGE));
  assign mem_we  = cmd.clear_en || (cmd.wr_entry && wr_in_range);
  assign wr_addr = cmd.clear_en ? clr_cnt_r
                                : {STG_W'(in_stage_index), SLOT_W'(in_slot_index)};
  assign wr_data = cmd.clear_en ? '0 : {in_dest_base, in_source_base, in_span_length};
  assign rd_addr = {iss_stage_r[STG_W-1:0], iss_slot_r};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  // Stage limit, clipped to the table size.
  assign n_load = (32'(stage_count_r) > 32'(MAX_STAGES)) ? CNT_W'(MAX_STAGES)
                                                         : CNT_W'(stage_count_r);

  // Span test and remap of the entry read in the previous cycle.
  assign {ent_dest, ent_src, ent_len} = rd_data_r;
  assign off = v_r - ent_src;
  assign hit = ev_vld_r && (off < ent_len);

  assign issuing  = iss_stage_r < n_r;
  assign iss_last = iss_slot_r == SLOT_W'(SLOTS_PER_STAGE - 1);

  always_comb begin
    iss_stage_nxt = iss_stage_r;
    iss_slot_nxt  = iss_slot_r;
    ev_vld_nxt    = 1'b0;
    if (cmd.load) begin
      iss_stage_nxt = '0;
      iss_slot_nxt  = '0;
    end else if (cmd.scan_en) begin
      if (hit && !ev_last_r) begin
        // The read in flight belongs to the stage just resolved: drop it.
        iss_stage_nxt = iss_stage_r + CNT_W'(1);
        iss_slot_nxt  = '0;
      end else if (issuing) begin
        ev_vld_nxt = 1'b1;
        if (iss_last) begin
          iss_stage_nxt = iss_stage_r + CNT_W'(1);
          iss_slot_nxt  = '0;
        end else begin
          iss_slot_nxt = iss_slot_r + SLOT_W'(1);
        end
      end
    end
  end

  assign status.clear_done = clr_cnt_r == ADDR_W'(DEPTH - 1);
  assign status.scan_done  = !issuing && !ev_vld_r;

  assign min_nxt = (v_r < min_r) ? v_r : min_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_count_r <= STAGE_COUNT_RST;
      clr_cnt_r     <= '0;
      ev_vld_r      <= 1'b0;
      min_r         <= '1;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        stage_count_r <= cfg_wr_data;
      end
      if (cmd.clear_en) begin
        clr_cnt_r <= clr_cnt_r + ADDR_W'(1);
      end
      ev_vld_r    <= ev_vld_nxt;
      out_valid_r <= cmd.emit;
      if (cmd.min_rst) begin
        min_r <= '1;
      end else if (cmd.emit) begin
        min_r <= min_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    iss_stage_r <= iss_stage_nxt;
    iss_slot_r  <= iss_slot_nxt;
    ev_last_r   <= iss_last;
    if (cmd.load) begin
      n_r <= n_load;
      v_r <= in_seed_value;
    end else if (hit) begin
      v_r <= ent_dest + off;
    end
    if (cmd.emit) begin
      out_mapped_r <= v_r;
      out_min_r    <= min_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_mapped_value = out_mapped_r;
  assign out_running_min  = out_min_r;

endmodule

`default_nettype wire

### design/chained_range_remap_min.sv
// Chained range remap with running minimum.
//
// Input channel: a transaction is taken at a rising edge where start is high
// and busy is low. in_cmd selects the operation. A table write (stage, slot,
// destination base, source base, span length) and a running-minimum reset
// take effect at that edge, produce no result and keep busy low, so another
// transaction may follow in the next cycle. A translate transaction raises
// busy while the seed value is walked through the active stages.
// Result channel: out_valid is high for exactly one cycle with
// out_mapped_value and out_running_min. The receiver cannot stall it.
// Scan: one table slot is read per cycle with registered read data, except
// that a match outside a stage's last slot pauses the reads while the scan
// moves on to the next stage. A stage ends at its first matching slot and
// otherwise reads every slot. busy drops as out_valid rises, so the next
// transaction may be taken in the cycle the result is shown.
// Reset: the stage count returns to 7, the running minimum to all ones, and
// the table is cleared one entry per cycle with busy high. Configuration
// writes are taken at any time.
`timescale 1ns / 1ps
`default_nettype none

module chained_range_remap_min #(
  parameter int MAX_STAGES      = crrm_pkg::MAX_STAGES_DEF,
  parameter int SLOTS_PER_STAGE = crrm_pkg::SLOTS_PER_STAGE_DEF
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               cfg_wr_en,
  input  wire  [crrm_pkg::CFG_W-1:0]        cfg_wr_data,
  input  wire                               start,
  output logic                              busy,
  input  wire  [crrm_pkg::CMD_W-1:0]        in_cmd,
  input  wire  [crrm_pkg::STAGE_IDX_W-1:0]  in_stage_index,
  input  wire  [crrm_pkg::SLOT_IDX_W-1:0]   in_slot_index,
  input  wire  [crrm_pkg::VAL_W-1:0]        in_dest_base,
  input  wire  [crrm_pkg::VAL_W-1:0]        in_source_base,
  input  wire  [crrm_pkg::VAL_W-1:0]        in_span_length,
  input  wire  [crrm_pkg::VAL_W-1:0]        in_seed_value,
  output logic                              out_valid,
  output logic [crrm_pkg::VAL_W-1:0]        out_mapped_value,
  output logic [crrm_pkg::VAL_W-1:0]        out_running_min
);
  import crrm_pkg::*;

  // Commands from the sequencer and status back from the datapath.
  ctl_cmd_t   ctl_cmd;
  dp_status_t dp_status;

  // The sequencer owns the handshake: clearing after reset, idle, scanning.
  crrm_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .in_cmd (in_cmd),
    .status (dp_status),
    .cmd    (ctl_cmd),
    .busy   (busy)
  );

  // The datapath holds the table memory, scan pointers, value and minimum.
  crrm_dpath #(
    .MAX_STAGES      (MAX_STAGES),
    .SLOTS_PER_STAGE (SLOTS_PER_STAGE)
  ) u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (ctl_cmd),
    .status           (dp_status),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_stage_index   (in_stage_index),
    .in_slot_index    (in_slot_index),
    .in_dest_base     (in_dest_base),
    .in_source_base   (in_source_base),
    .in_span_length   (in_span_length),
    .in_seed_value    (in_seed_value),
    .out_valid        (out_valid),
    .out_mapped_value (out_mapped_value),
    .out_running_min  (out_running_min)
  );

endmodule

`default_nettype wire

### design/crrm_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module crrm_checker (
  input wire                         clk,
  input wire                         rst_n,
  input wire                         start,
  input wire                         busy,
  input wire [crrm_pkg::CMD_W-1:0]   in_cmd,
  input wire                         out_valid,
  input wire [crrm_pkg::VAL_W-1:0]   out_mapped_value,
  input wire [crrm_pkg::VAL_W-1:0]   out_running_min
);
  import crrm_pkg::*;

  // The reported minimum already includes the value reported with it.
  a_min_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_running_min <= out_mapped_value)
    else $error("running minimum above mapped value");

  // A translate occupies the block until its result is out.
  a_xlate_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_cmd == CMD_XLATE) |=> busy)
    else $error("translate accepted without going busy");

  // Every result follows a busy scan cycle.
  a_result_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result without a preceding scan");

  // The table clearing sweep starts right after reset.
  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> busy)
    else $error("not busy after reset");

endmodule

bind chained_range_remap_min crrm_checker u_crrm_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .in_cmd           (in_cmd),
  .out_valid        (out_valid),
  .out_mapped_value (out_mapped_value),
  .out_running_min  (out_running_min)
);

`default_nettype wire

### tb/chained_range_remap_min_tb.sv
`timescale 1ns / 1ps

module chained_range_remap_min_tb;
  import crrm_pkg::*;

  // The table size follows the block's default parameters.
  localparam int N_STAGES = MAX_STAGES_DEF;
  localparam int N_SLOTS = SLOTS_PER_STAGE_DEF;

  // Command code 3 has no meaning in the block; it must be ignored.
  localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;

  // A translate scans at most 8 x 64 slots, so this limit is ample for any
  // outstanding result to show up.
  localparam int DRAIN_LIMIT = 4000;
  // Extra cycles after the last result before a register write or the end.
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASES = 6;
  localparam int ITEMS_PER_PHASE = 192;

  typedef struct packed {
    logic [CMD_W-1:0]       cmd;
    logic [STAGE_IDX_W-1:0] stage;
    logic [SLOT_IDX_W-1:0]  slot;
    logic [VAL_W-1:0]       dest;
    logic [VAL_W-1:0]       src;
    logic [VAL_W-1:0]       len;
    logic [VAL_W-1:0]       seed;
  } remap_item_t;

  typedef struct packed {
    logic [VAL_W-1:0] mapped;
    logic [VAL_W-1:0] least;
  } remap_result_t;

  // Every input is known from time zero; reset is held low from the start.
  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_wr_en = 1'b0;
  logic [CFG_W-1:0]       cfg_wr_data = '0;
  logic                   start = 1'b0;
  logic                   busy;
  logic [CMD_W-1:0]       in_cmd = '0;
  logic [STAGE_IDX_W-1:0] in_stage_index = '0;
  logic [SLOT_IDX_W-1:0]  in_slot_index = '0;
  logic [VAL_W-1:0]       in_dest_base = '0;
  logic [VAL_W-1:0]       in_source_base = '0;
  logic [VAL_W-1:0]       in_span_length = '0;
  logic [VAL_W-1:0]       in_seed_value = '0;
  logic                   out_valid;
  logic [VAL_W-1:0]       out_mapped_value;
  logic [VAL_W-1:0]       out_running_min;

  chained_range_remap_min dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .start            (start),
    .busy             (busy),
    .in_cmd           (in_cmd),
    .in_stage_index   (in_stage_index),
    .in_slot_index    (in_slot_index),
    .in_dest_base     (in_dest_base),
    .in_source_base   (in_source_base),
    .in_span_length   (in_span_length),
    .in_seed_value    (in_seed_value),
    .out_valid        (out_valid),
    .out_mapped_value (out_mapped_value),
    .out_running_min  (out_running_min)
  );

  // 4 ns clock: two ns high, two ns low.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Shadow copy of the block's state, updated at each accepted transaction.
  logic [VAL_W-1:0] tbl_dest [N_STAGES][N_SLOTS];
  logic [VAL_W-1:0] tbl_src  [N_STAGES][N_SLOTS];
  logic [VAL_W-1:0] tbl_len  [N_STAGES][N_SLOTS];
  logic [CFG_W-1:0] cur_stage_count;
  logic [VAL_W-1:0] cur_least;

  // Results predicted for accepted translates, oldest first.
  remap_result_t pending_remaps[$];

  int unsigned fail_count = 0;
  int unsigned checked_count = 0;
  int unsigned xlate_count = 0;
  int unsigned write_count = 0;
  int unsigned minrst_count = 0;
  int unsigned nop_count = 0;

  function automatic void clear_shadow();
    int s;
    int k;
    for (s = 0; s < N_STAGES; s++) begin
      for (k = 0; k < N_SLOTS; k++) begin
        tbl_dest[s][k] = '0;
        tbl_src[s][k] = '0;
        tbl_len[s][k] = '0;
      end
    end
    cur_stage_count = STAGE_COUNT_RST;
    cur_least = '1;
  endfunction

  // Walks a value through the active stages. In each stage only the first
  // slot whose span holds the value applies. The span test uses a wrapping
  // offset, so a span that runs past the top of the range continues at zero.
  function automatic logic [VAL_W-1:0] walk_stages(logic [VAL_W-1:0] seed);
    logic [VAL_W-1:0] v;
    logic [VAL_W-1:0] off;
    int unsigned n;
    int s;
    int k;
    bit hit;
    v = seed;
    n = (cur_stage_count > N_STAGES) ? N_STAGES : cur_stage_count;
    for (s = 0; s < n; s++) begin
      hit = 1'b0;
      for (k = 0; k < N_SLOTS; k++) begin
        off = v - tbl_src[s][k];
        if (!hit && off < tbl_len[s][k]) begin
          v = tbl_dest[s][k] + off;
          hit = 1'b1;
        end
      end
    end
    return v;
  endfunction

  // Applies one accepted transaction to the shadow state.
  function automatic void apply_item(remap_item_t it);
    remap_result_t r;
    case (it.cmd)
      CMD_WRITE: begin
        // Writes outside the table are dropped; with the default sizes every
        // index fits, but the guard keeps the shadow honest.
        if (it.stage < N_STAGES && it.slot < N_SLOTS) begin
          tbl_dest[it.stage][it.slot] = it.dest;
          tbl_src[it.stage][it.slot] = it.src;
          tbl_len[it.stage][it.slot] = it.len;
        end
        write_count++;
      end
      CMD_XLATE: begin
        r.mapped = walk_stages(it.seed);
        if (r.mapped < cur_least) cur_least = r.mapped;
        r.least = cur_least;
        pending_remaps = {pending_remaps, r};
        xlate_count++;
      end
      CMD_MIN_RST: begin
        cur_least = '1;
        minrst_count++;
      end
      default: begin
        nop_count++;
      end
    endcase
  endfunction

  // Each result is compared with the oldest prediction. Outputs are sampled
  // at the rising edge, before the block's own updates of that edge land.
  remap_result_t due;
  always @(posedge clk) begin
    if (out_valid === 1'b1) begin
      if (pending_remaps.size() == 0) begin
        $error("unexpected result: mapped_value %h running_min %h",
               out_mapped_value, out_running_min);
        fail_count++;
      end else begin
        due = pending_remaps.pop_front();
        checked_count++;
        if (out_mapped_value !== due.mapped) begin
          $error("mapped_value mismatch: expected %h, actual %h",
                 due.mapped, out_mapped_value);
          fail_count++;
        end
        if (out_running_min !== due.least) begin
          $error("running_min mismatch: expected %h, actual %h",
                 due.least, out_running_min);
          fail_count++;
        end
      end
    end
  end

  // Presents one transaction at the falling edge and holds it until the block
  // takes it: start high and busy low at a rising edge. Start is left high on
  // return so that transactions can follow back to back.
  task automatic send_item(remap_item_t it);
    @(negedge clk);
    start <= 1'b1;
    in_cmd <= it.cmd;
    in_stage_index <= it.stage;
    in_slot_index <= it.slot;
    in_dest_base <= it.dest;
    in_source_base <= it.src;
    in_span_length <= it.len;
    in_seed_value <= it.seed;
    do @(posedge clk); while (busy !== 1'b0);
    apply_item(it);
  endtask

  // Lowers start and lets the given number of cycles pass.
  task automatic hold_off(int unsigned cycles);
    @(negedge clk);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Stops sending and waits until every predicted result has arrived and the
  // block is idle, then waits out the settling period.
  task automatic drain_results();
    int unsigned waited;
    waited = 0;
    @(negedge clk);
    start <= 1'b0;
    while ((pending_remaps.size() != 0 || busy !== 1'b0) && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (waited >= DRAIN_LIMIT) begin
      $error("%0d results still outstanding after %0d cycles",
             pending_remaps.size(), DRAIN_LIMIT);
      fail_count++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes the stage count. Callers drain first, so no translate is in flight.
  task automatic cfg_write(logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= CFG_W'($urandom);
    cur_stage_count = value;
  endtask

  // A transaction with every field random; callers overwrite what matters.
  // Fields a command does not use still toggle this way.
  function automatic remap_item_t filler_item();
    remap_item_t it;
    it.cmd = CMD_W'($urandom);
    it.stage = STAGE_IDX_W'($urandom);
    it.slot = SLOT_IDX_W'($urandom);
    it.dest = $urandom;
    it.src = $urandom;
    it.len = $urandom;
    it.seed = $urandom;
    return it;
  endfunction

  task automatic post_write(int unsigned stage, int unsigned slot,
                            logic [VAL_W-1:0] dest, logic [VAL_W-1:0] src,
                            logic [VAL_W-1:0] len);
    remap_item_t it;
    it = filler_item();
    it.cmd = CMD_WRITE;
    it.stage = STAGE_IDX_W'(stage);
    it.slot = SLOT_IDX_W'(slot);
    it.dest = dest;
    it.src = src;
    it.len = len;
    send_item(it);
  endtask

  task automatic post_translate(logic [VAL_W-1:0] seed);
    remap_item_t it;
    it = filler_item();
    it.cmd = CMD_XLATE;
    it.seed = seed;
    send_item(it);
  endtask

  task automatic post_command(logic [CMD_W-1:0] cmd);
    remap_item_t it;
    it = filler_item();
    it.cmd = cmd;
    send_item(it);
  endtask

  // Values cluster in a small window near zero and one near the top of the
  // range, so random entries overlap and chain through the stages, and spans
  // near the top wrap round.
  function automatic logic [VAL_W-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return VAL_W'($urandom_range(0, 4095));
    if (r < 85) return 32'hFFFF_F000 + VAL_W'($urandom_range(0, 4095));
    return $urandom;
  endfunction

  function automatic logic [VAL_W-1:0] pick_span();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 8) return '0;
    if (r < 65) return VAL_W'($urandom_range(1, 512));
    if (r < 88) return VAL_W'($urandom_range(1, 4096));
    return $urandom;
  endfunction

  // Low slots most of the time: a hit there ends the stage scan early, which
  // keeps the run short; the full slot range still shows up.
  function automatic int unsigned pick_slot();
    if ($urandom_range(0, 3) != 0) return $urandom_range(0, 7);
    return $urandom_range(0, N_SLOTS - 1);
  endfunction

  function automatic remap_item_t random_item();
    remap_item_t it;
    int unsigned r;
    int unsigned s;
    int unsigned k;
    it = filler_item();
    r = $urandom_range(0, 99);
    if (r < 30) begin
      it.cmd = CMD_WRITE;
      it.stage = STAGE_IDX_W'($urandom_range(0, N_STAGES - 1));
      it.slot = SLOT_IDX_W'(pick_slot());
      it.dest = pick_value();
      it.src = pick_value();
      it.len = pick_span();
    end else if (r < 88) begin
      it.cmd = CMD_XLATE;
      s = $urandom_range(0, N_STAGES - 1);
      k = pick_slot();
      // Most seeds aim at an existing entry: inside it, on its first or
      // last value, or just past its end.
      case ($urandom_range(0, 5))
        0: it.seed = pick_value();
        1: it.seed = tbl_src[s][k];
        2: it.seed = tbl_src[s][k] + tbl_len[s][k] - 1;
        3: it.seed = tbl_src[s][k] + tbl_len[s][k];
        default: begin
          it.seed = tbl_src[s][k];
          if (tbl_len[s][k] != 0) it.seed = tbl_src[s][k] + ($urandom % tbl_len[s][k]);
        end
      endcase
    end else if (r < 94) begin
      it.cmd = CMD_MIN_RST;
    end else begin
      it.cmd = CMD_NOP;
    end
    return it;
  endfunction

  // Straight after reset the table is empty, so every value passes through
  // unchanged, and the minimum starts from all ones.
  task automatic test_reset_state();
    post_translate('1);
    post_translate(32'h1234_5678);
    post_translate('0);
  endtask

  // Span edges, slot priority, a span that wraps past the top of the range,
  // a destination that wraps, and retiring an entry with a zero length.
  task automatic test_span_rules();
    post_write(0, 0, 32'd100, 32'd10, 32'd5);
    post_translate(32'd10);
    post_translate(32'd14);
    post_translate(32'd15);
    post_write(0, 1, 32'd5000, 32'd10, 32'd100);
    post_translate(32'd12);
    post_translate(32'd50);
    post_write(1, 63, 32'h0000_1000, 32'hFFFF_FFF0, 32'h20);
    post_translate('1);
    post_translate(32'd5);
    post_write(2, 0, '1, 32'h0000_2000, 32'h10);
    post_translate(32'h0000_2001);
    post_write(0, 0, '1, '1, '0);
    post_translate(32'd12);
  endtask

  // Clearing the minimum, and the unused command code changing nothing.
  task automatic test_min_and_unused();
    post_command(CMD_MIN_RST);
    post_translate(32'h8000_0000);
    post_command(CMD_NOP);
    post_translate(32'h9000_0000);
  endtask

  // The last stage only acts once the stage count reaches the table depth.
  // A count above the depth behaves as the depth, and zero bypasses all.
  task automatic test_stage_count_limits();
    post_write(N_STAGES - 1, N_SLOTS - 1, '1, '0, '1);
    drain_results();
    cfg_write(CFG_W'(N_STAGES));
    post_translate('0);
    drain_results();
    cfg_write('1);
    post_translate(32'd12);
    drain_results();
    cfg_write('0);
    post_translate(32'd12);
    drain_results();
    cfg_write(CFG_W'(1));
    post_translate(32'd12);
  endtask

  // Random traffic in phases, one stage count per phase. The sender works in
  // bursts with random gaps, except in one steady phase; one phase also
  // stops midway until every result has come back.
  task automatic test_random_traffic();
    logic [CFG_W-1:0] phase_counts [PHASES];
    int unsigned burst_left;
    int unsigned p;
    int unsigned i;
    bit steady;
    phase_counts[0] = CFG_W'(N_STAGES);
    phase_counts[1] = CFG_W'(1);
    phase_counts[2] = '1;
    phase_counts[3] = '0;
    phase_counts[4] = CFG_W'($urandom_range(2, N_STAGES - 1));
    phase_counts[5] = CFG_W'($urandom);
    for (p = 0; p < PHASES; p++) begin
      drain_results();
      cfg_write(phase_counts[p]);
      steady = (p == 2);
      burst_left = $urandom_range(1, 24);
      for (i = 0; i < ITEMS_PER_PHASE; i++) begin
        if (p == 1 && i == ITEMS_PER_PHASE / 2) drain_results();
        if (!steady && burst_left == 0) begin
          hold_off($urandom_range(1, 40));
          burst_left = $urandom_range(1, 24);
        end
        send_item(random_item());
        if (burst_left != 0) burst_left--;
      end
    end
  endtask

  // After reset is released, the block clears its table, keeping busy high,
  // and the first transaction simply waits for that to finish.
  initial begin
    clear_shadow();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_state();
    test_span_rules();
    test_min_and_unused();
    test_stage_count_limits();
    test_random_traffic();

    drain_results();
    if (pending_remaps.size() != 0) begin
      $error("%0d predicted results never arrived", pending_remaps.size());
      fail_count++;
    end

    $display("Sent %0d translates, %0d table writes, %0d minimum clears, %0d unused codes;",
             xlate_count, write_count, minrst_count, nop_count);
    $display("checked %0d results over stage counts from zero to fifteen.", checked_count);
    if (fail_count == 0) begin
      $display("chained_range_remap_min_tb passed");
    end else begin
      $display("chained_range_remap_min_tb failed");
    end
    $finish;
  end

  // The slowest correct run is about 1200 transactions, each a full scan plus
  // the longest gap, well under three milliseconds.
  // Twenty milliseconds leaves a wide margin for the drains and reset sweep.
  initial begin
    #20_000_000;
    $display("chained_range_remap_min_tb failed");
    $finish;
  end

endmodule
